FILE: sv/apsp_pkg.sv
// Shared types and constants of the all-pairs shortest path engine.
`default_nettype none
package apsp_pkg;
    localparam int MaxNodes = 32;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int AddrW    = 2 * NodeW;
    localparam int DistW    = 22;
    localparam int CountW   = 6;
    localparam int WeightW  = 17;
    localparam logic [DistW-1:0] DistInf = {DistW{1'b1}};

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_ROW,
        ST_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CMD,
        RD_PIVOT,
        RD_IK,
        RD_ELEM
    } t_rd_kind;

    typedef struct packed {
        logic shift;
        logic is_tail;
    } t_cell_ctl;

    // Sum of two distances that saturates at the infinity code.
    function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                                 input logic [DistW-1:0] b);
        logic [DistW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == DistInf || b == DistInf || s >= {1'b0, DistInf}) begin
            return DistInf;
        end
        return s[DistW-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: sv/apsp_mem.sv
// Distance matrix storage with one write port and one registered read port.
`default_nettype none
module apsp_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [apsp_pkg::AddrW-1:0]  i_waddr,
    input  wire logic [apsp_pkg::DistW-1:0]  i_wdata,
    input  wire logic [apsp_pkg::AddrW-1:0]  i_raddr,
    output logic      [apsp_pkg::DistW-1:0]  o_rdata
);
    import apsp_pkg::*;

    logic [DistW-1:0] r_mem [MaxNodes*MaxNodes];
    logic [DistW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: sv/apsp_cell.sv
// One cell of the pivot-row chain: holds one distance and shifts it onwards.
`default_nettype none
module apsp_cell (
    input  wire logic                        i_clk,
    input  wire apsp_pkg::t_cell_ctl         i_ctl,
    input  wire logic [apsp_pkg::DistW-1:0]  i_next,
    input  wire logic [apsp_pkg::DistW-1:0]  i_tail,
    output logic      [apsp_pkg::DistW-1:0]  o_value
);
    import apsp_pkg::*;

    logic [DistW-1:0] r_value;
    logic [DistW-1:0] n_value;

    // The last cell in use takes the tail input; the others take their neighbour.
    always_comb begin
        n_value = r_value;
        if (i_ctl.shift) begin
            n_value = i_ctl.is_tail ? i_tail : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
endmodule
`default_nettype wire

FILE: sv/all_pairs_shortest_path.sv
// Top level of the all-pairs shortest path engine: sequencer, cell chain and storage.
//
// Channel  | Direction | Handshake                  | Beat contents
// command  | in        | start high while busy low  | command, row, column, weight
// result   | out       | o_valid for one cycle      | distance, reachable flag
// config   | in        | i_cfg_we                   | node_count
//
// Write and read beats are taken one per cycle while busy is low; a read answers
// in the cycle right after its beat is taken, on o_valid, and the receiver cannot
// stall the result. A solve holds busy until it is done, its pace set by the
// single read port of the distance memory, which delivers one entry per cycle.
// Reset is synchronous and active low; it clears the sequencer and node_count
// (to 32) but not the distance memory, which is undefined until written.
`default_nettype none
module all_pairs_shortest_path (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_command,
    input  wire logic [apsp_pkg::NodeW-1:0]    i_row_node,
    input  wire logic [apsp_pkg::NodeW-1:0]    i_col_node,
    input  wire logic signed [apsp_pkg::WeightW-1:0] i_edge_weight,
    input  wire logic                          i_cfg_we,
    input  wire logic [apsp_pkg::CountW-1:0]   i_cfg_data,
    output logic                               o_valid,
    output logic      [apsp_pkg::DistW-1:0]    o_distance,
    output logic                               o_reachable
);
    import apsp_pkg::*;

    // Sequencer state and loop counters: k is the pivot, i the row, j the column.
    t_state            r_state, n_state;
    logic [NodeW-1:0]  r_k, n_k;
    logic [NodeW-1:0]  r_i, n_i;
    logic [NodeW-1:0]  r_j, n_j;
    logic [NodeW-1:0]  r_nm1, n_nm1;
    logic [CountW-1:0] r_node_count;

    // Read pipeline tag: what the memory data in this cycle belongs to.
    t_rd_kind          r_kind, n_kind;
    logic [AddrW-1:0]  r_wb_addr, n_wb_addr;
    logic [DistW-1:0]  r_dik;

    logic              accept;
    t_cmd              cmd;
    logic [AddrW-1:0]  raddr;
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [DistW-1:0]  wdata;
    logic [DistW-1:0]  rdata;
    logic [DistW-1:0]  via;
    logic [DistW-1:0]  tail_in;
    logic [DistW-1:0]  cell_val [MaxNodes];
    logic              chain_shift;

    assign cmd    = t_cmd'(i_command);
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CountW'(MaxNodes);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Next state, counters and the address presented to the read port.
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_nm1     = r_nm1;
        n_kind    = RD_NONE;
        n_wb_addr = {r_i, r_j};
        raddr     = {i_row_node, i_col_node};
        unique case (r_state)
            ST_IDLE: begin
                if (accept && cmd == CMD_READ) begin
                    n_kind = RD_CMD;
                end
                if (accept && cmd == CMD_SOLVE && r_node_count != '0) begin
                    n_state = ST_LOAD;
                    n_k     = '0;
                    n_j     = '0;
                    if (r_node_count > CountW'(MaxNodes)) begin
                        n_nm1 = NodeW'(MaxNodes - 1);
                    end else begin
                        n_nm1 = NodeW'(r_node_count - 1'b1);
                    end
                end
            end
            ST_LOAD: begin
                raddr  = {r_k, r_j};
                n_kind = RD_PIVOT;
                n_j    = r_j + 1'b1;
                if (r_j == r_nm1) begin
                    n_state = ST_FETCH;
                    n_i     = '0;
                end
            end
            ST_FETCH: begin
                raddr   = {r_i, r_k};
                n_kind  = RD_IK;
                n_j     = '0;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                raddr  = {r_i, r_j};
                n_kind = RD_ELEM;
                n_j    = r_j + 1'b1;
                if (r_j == r_nm1) begin
                    if (r_i != r_nm1) begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_FETCH;
                    end else if (r_k != r_nm1) begin
                        n_k     = r_k + 1'b1;
                        n_j     = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Lets the final relaxation write land before new commands.
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= RD_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_i       <= n_i;
        r_j       <= n_j;
        r_nm1     <= n_nm1;
        r_wb_addr <= n_wb_addr;
        if (r_kind == RD_IK) begin
            r_dik <= rdata;
        end
    end

    // Relaxation: the head cell holds d[k][j] for the entry arriving now.
    assign via = sat_add(r_dik, cell_val[0]);

    always_comb begin
        we    = 1'b0;
        waddr = {i_row_node, i_col_node};
        wdata = i_edge_weight[WeightW-1] ? DistInf
                                         : DistW'(i_edge_weight[WeightW-2:0]);
        if (r_state == ST_IDLE && accept && cmd == CMD_WRITE) begin
            we = 1'b1;
        end
        if (r_kind == RD_ELEM) begin
            waddr = r_wb_addr;
            wdata = via;
            we    = (via < rdata);
        end
    end

    apsp_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // The chain shifts in the pivot row while loading and rotates by one cell
    // per relaxed entry, so that after a full row it is back where it began.
    assign chain_shift = (r_kind == RD_PIVOT) || (r_kind == RD_ELEM);
    assign tail_in     = (r_kind == RD_PIVOT) ? rdata : cell_val[0];

    for (genvar c = 0; c < MaxNodes; c++) begin : g_cell
        t_cell_ctl        ctl;
        logic [DistW-1:0] next_val;
        assign ctl.shift   = chain_shift;
        assign ctl.is_tail = (NodeW'(c) == r_nm1);
        if (c == MaxNodes - 1) begin : g_last
            assign next_val = tail_in;
        end else begin : g_mid
            assign next_val = cell_val[c+1];
        end
        apsp_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_next  (next_val),
            .i_tail  (tail_in),
            .o_value (cell_val[c])
        );
    end

    assign o_valid     = (r_kind == RD_CMD);
    assign o_distance  = rdata;
    assign o_reachable = (rdata != DistInf);

    // A result beat only ever follows a read command taken in the previous cycle.
    a_result_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && cmd == CMD_READ))
        else $error("result beat without a read command");

    // Busy only rises when a solve command has been taken.
    a_busy_from_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(accept && cmd == CMD_SOLVE))
        else $error("busy rose without a solve command");

    // No result beat is produced while a solve is in its load or row states.
    a_no_result_in_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW || r_state == ST_LOAD) |-> !o_valid)
        else $error("result beat during a solve");
endmodule
`default_nettype wire
